/* rtl/core/bounded_deque_unit_macros.svh */
// assertion macros shared by the deque checker
`ifndef BOUNDED_DEQUE_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_UNIT_MACROS_SVH

// concurrent assertion on an explicit clock and reset
`define BDQ_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define BDQ_ASSERT(lbl, prop, msg) \
   `BDQ_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

/* rtl/core/bdq_pkg.sv */
// types, constants and helpers for the bounded deque
package bdq_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int SUM_W    = CNT_W + 1;
   localparam int DATA_W   = 32;
   localparam int ENTRY_W  = 5;

   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_TUSER_W = 2;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY_POP = 2'd1,
      ST_FULL_PUSH = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_RESP = 1'b1
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } mem_req_type;

   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] popped;
      logic              pop_from_mem;
      logic              refill_front;
   } pend_type;

   typedef struct packed {
      logic [DATA_W-1:0]  popped_value;
      status_type         status;
      logic [DATA_W-1:0]  front_value;
      logic               is_empty;
      logic [ENTRY_W-1:0] entry_count;
   } result_type;

   // slot that lies off steps past base, wrapping round the ring
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

/* rtl/core/bdq_ram.sv */
// simple dual-port ram with registered read data
module bdq_ram #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/bdq_ctrl.sv */
// ring pointers, cached front word and per-beat sequencing
module bdq_ctrl
   import bdq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  op_type            req_kind,
   input  logic [DATA_W-1:0] req_value,
   input  logic [DATA_W-1:0] rd_data,
   output mem_req_type       mem_req,
   output logic              res_valid,
   output result_type        res,
   input  logic              res_ready
);

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  front_ff, front_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] front_word_ff, front_word_in;
   pend_type          pend_ff, pend_in;

   logic              accept;
   logic              is_full;
   logic              is_empty_now;
   logic [DATA_W-1:0] front_word_eff;
   logic [IDX_W-1:0]  front_next;
   logic [IDX_W-1:0]  front_prev;

   // a pop-front refill lands in the ram read register in the next cycle
   assign front_word_eff = (state_ff == S_RESP && pend_ff.refill_front) ? rd_data
                                                                       : front_word_ff;

   assign is_full      = (count_ff == CNT_W'(CAPACITY));
   assign is_empty_now = (count_ff == '0);
   assign front_next   = ring_add(front_ff, CNT_W'(1));
   assign front_prev   = (front_ff == '0) ? IDX_W'(CAPACITY - 1) : front_ff - 1'b1;

   assign res_valid = (state_ff == S_RESP);
   assign req_ready = (state_ff == S_IDLE) || res_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      res.popped_value = pend_ff.pop_from_mem ? rd_data : pend_ff.popped;
      res.status       = pend_ff.status;
      res.front_value  = (count_ff == '0) ? '0 : front_word_eff;
      res.is_empty     = (count_ff == '0);
      res.entry_count  = ENTRY_W'(count_ff);
   end

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      front_word_in = front_word_eff;
      pend_in       = pend_ff;
      mem_req       = '0;

      if (state_ff == S_RESP && res_ready) begin
         state_in = S_IDLE;
      end

      if (accept) begin
         state_in             = S_RESP;
         pend_in.status       = ST_OK;
         pend_in.popped       = '0;
         pend_in.pop_from_mem = 1'b0;
         pend_in.refill_front = 1'b0;
         unique case (req_kind)
            OP_PUSH_FRONT: begin
               if (is_full) begin
                  pend_in.status = ST_FULL_PUSH;
               end else begin
                  front_in        = front_prev;
                  count_in        = count_ff + 1'b1;
                  front_word_in   = req_value;
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = front_prev;
                  mem_req.wr_data = req_value;
               end
            end
            OP_PUSH_BACK: begin
               if (is_full) begin
                  pend_in.status = ST_FULL_PUSH;
               end else begin
                  count_in        = count_ff + 1'b1;
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = ring_add(front_ff, count_ff);
                  mem_req.wr_data = req_value;
                  if (is_empty_now) begin
                     front_word_in = req_value;
                  end
               end
            end
            OP_POP_FRONT: begin
               if (is_empty_now) begin
                  pend_in.status = ST_EMPTY_POP;
               end else begin
                  pend_in.popped       = front_word_eff;
                  pend_in.refill_front = 1'b1;
                  count_in             = count_ff - 1'b1;
                  front_in             = (count_ff == CNT_W'(1)) ? '0 : front_next;
                  mem_req.rd_en        = 1'b1;
                  mem_req.rd_addr      = front_next;
               end
            end
            OP_POP_BACK: begin
               if (is_empty_now) begin
                  pend_in.status = ST_EMPTY_POP;
               end else begin
                  pend_in.pop_from_mem = 1'b1;
                  count_in             = count_ff - 1'b1;
                  mem_req.rd_en        = 1'b1;
                  mem_req.rd_addr      = ring_add(front_ff, count_ff - 1'b1);
                  if (count_ff == CNT_W'(1)) begin
                     front_in = '0;
                  end
               end
            end
            default: begin
               pend_in.status = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      front_word_ff <= front_word_in;
      pend_ff       <= pend_in;
   end

endmodule

/* rtl/core/bdq_out.sv */
// output register that holds one result beat
module bdq_out
   import bdq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       res_valid,
   input  result_type res,
   output logic       res_ready,
   output logic       out_valid,
   output result_type out_res,
   input  logic       out_ready
);

   logic       valid_ff, valid_in;
   result_type res_ff;
   logic       load;

   assign res_ready = !valid_ff || out_ready;
   assign load      = res_valid && res_ready;

   always_comb begin
      valid_in = valid_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;

endmodule

/* rtl/core/bounded_deque_unit.sv */
// bounded deque of signed words held in a ring buffer ram
// a result beat is registered first in the control stage and then in the output
// register before it shows on rsp
// throughput: one request per cycle while rsp is not stalled; the front word is
// cached, so the ram read never holds up the next request
// reset: synchronous, clears pointers, count and valid flags; ram left unwritten
module bounded_deque_unit
   import bdq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [31:0] value
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // [1:0] kind
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] popped_value, [63:32] front_value, [64] is_empty,
   // [69:65] entry_count, [71:70] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [RSP_TUSER_W-1:0] rsp_tuser   // [1:0] status
);

   mem_req_type       mem_req;
   logic [DATA_W-1:0] rd_data;
   logic              res_valid;
   logic              res_ready;
   result_type        res;
   result_type        out_res;

   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (op_type'(req_tuser)),
      .req_value (req_tdata[DATA_W-1:0]),
      .rd_data   (rd_data),
      .mem_req   (mem_req),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   bdq_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   bdq_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready),
      .out_valid (rsp_tvalid),
      .out_res   (out_res),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {2'b00, out_res.entry_count, out_res.is_empty,
                       out_res.front_value, out_res.popped_value};
   assign rsp_tuser = out_res.status;

endmodule

/* rtl/core/bdq_checker.sv */
// port-level checker for the bounded deque, bound to the top level
`include "bounded_deque_unit_macros.svh"

module bdq_checker
   import bdq_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [RSP_TUSER_W-1:0] rsp_tuser
);

   logic                               rsp_stall;
   logic                               rsp_empty;
   logic [ENTRY_W-1:0]                 rsp_count;
   logic [DATA_W-1:0]                  rsp_front;
   logic [DATA_W-1:0]                  rsp_popped;
   logic [RSP_TDATA_W+RSP_TUSER_W-1:0] rsp_beat;

   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_empty  = rsp_tdata[64];
   assign rsp_count  = rsp_tdata[69:65];
   assign rsp_front  = rsp_tdata[63:32];
   assign rsp_popped = rsp_tdata[31:0];
   assign rsp_beat   = {rsp_tuser, rsp_tdata};

   `BDQ_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_beat), "rsp beat moved in stall")
   `BDQ_ASSERT(a_empty_count, rsp_tvalid |-> rsp_empty == (rsp_count == '0), "empty and count differ")
   `BDQ_ASSERT(a_empty_front, rsp_tvalid && rsp_empty |-> rsp_front == '0, "front set on empty queue")
   `BDQ_ASSERT(a_fail_no_pop, rsp_tvalid && rsp_tuser != ST_OK |-> rsp_popped == '0, "failed op gave a word")

endmodule

bind bounded_deque_unit bdq_checker u_bdq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
